// ----- hw/rtl/carrot_path_follower_defines.svh -----
// Assertion macros for the carrot path follower.
`ifndef CARROT_PATH_FOLLOWER_DEFINES_SVH
`define CARROT_PATH_FOLLOWER_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define CPF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define CPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/cpf_pkg.sv -----
// Shared constants, types and helpers of the carrot path follower.
package cpf_pkg;

  localparam int MAX_POINTS = 256;
  localparam int FRAC_BITS  = 16;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = PTR_W + 1;
  localparam int CRD_W      = 32;
  localparam int REG_W      = 31;
  localparam int CNT_REG_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int MAG_W      = CRD_W + 1;
  localparam int ACC_W      = 2 * MAG_W + 2;
  localparam int ROOT_W     = ACC_W / 2;
  localparam int RSQ_W      = 2 * REG_W;

  localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
  localparam longint STOP_EPS = (ONE_FX + 50) / 100;

  localparam logic [REG_W-1:0] LOOKAHEAD_RST = REG_W'((6 * ONE_FX + 5) / 10);
  localparam logic [REG_W-1:0] SPEED_RST     = REG_W'((3 * ONE_FX + 5) / 10);
  localparam logic [REG_W-1:0] ARRIVAL_RST   = REG_W'((ONE_FX + 5) / 10);
  localparam logic [REG_W-1:0] HOVER_RST     = REG_W'((5 * ONE_FX + 50) / 100);
  localparam logic [CNT_REG_W-1:0] COUNT_RST = CNT_REG_W'(1);
  localparam logic [ACC_W-1:0] STOP_EPS_SQ   = ACC_W'(STOP_EPS * STOP_EPS);

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_POS   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOKAHEAD = 3'd0,
    CFG_SPEED     = 3'd1,
    CFG_COUNT     = 3'd2,
    CFG_ARRIVAL   = 3'd3,
    CFG_HOVER     = 3'd4
  } cfg_idx_t;

  function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [CRD_W+1:0] v);
    logic signed [CRD_W+1:0] hi;
    logic signed [CRD_W+1:0] lo;
    hi = (CRD_W+2)'(signed'(CRD_W'({1'b0, {(CRD_W-1){1'b1}}})));
    lo = -hi - (CRD_W+2)'(1);
    if (v > hi) return hi[CRD_W-1:0];
    if (v < lo) return lo[CRD_W-1:0];
    return v[CRD_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/cpf_if.sv -----
// Valid/ready channel interfaces for the path follower input and result words.
interface cpf_in_if import cpf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [PTR_W-1:0]        point_index;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;

  modport source (output valid, kind, point_index, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, kind, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface cpf_out_if import cpf_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] vel_x;
  logic signed [CRD_W-1:0] vel_y;
  logic signed [CRD_W-1:0] vel_z;
  logic signed [CRD_W-1:0] carrot_x;
  logic signed [CRD_W-1:0] carrot_y;
  logic signed [CRD_W-1:0] carrot_z;
  logic                    following;
  logic [PTR_W-1:0]        nearest_index;

  modport source (output valid, vel_x, vel_y, vel_z, carrot_x, carrot_y, carrot_z,
                  following, nearest_index, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, carrot_x, carrot_y, carrot_z,
                following, nearest_index, output ready);
endinterface

// ----- hw/rtl/carrot_path_follower.sv -----
// Carrot path follower: one path memory, a sequencer and a shared multiply/root/divide datapath.
// Waypoint words are written into a 256 x 96-bit one-read one-write path memory and give no
// result. A position word runs alone through the sequencer. Before the first arrival it does
// no scan or walk; once following, its run time grows with the number of points scanned for
// the nearest waypoint and with the number of segments walked. The run time is set by the one
// 33x17 multiplier (two passes per product), the one-bit-per-cycle square root, the
// one-bit-per-cycle divider (one division per component) and one memory read per cycle. The
// input is taken again as soon as the sequencer is back to idle, even while the last result
// waits in the output register. The memory is not cleared at reset; reading a slot never
// written gives an undefined carrot.
`include "carrot_path_follower_defines.svh"

module carrot_path_follower import cpf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_wdata,
  cpf_in_if.sink               in_port,
  cpf_out_if.source            out_port
);

  typedef enum logic [4:0] {
    S_IDLE, S_RSQ, S_CAR_LD, S_SCAN_LD, S_SCAN_DIFF, S_SCAN_CMP,
    S_WALK_CHK, S_WALK_LD1, S_WALK_LD2, S_WALK_DIFF, S_SQD, S_SQRT,
    S_WALK_LEN, S_FIN_DIFF, S_FIN_TEST, S_FIN_VEL, S_MD_MUL, S_MD_DIV,
    S_MD_STORE, S_EMIT
  } state_t;

  // configuration
  logic [REG_W-1:0]     look_r, speed_r, arrival_r, hover_r;
  logic [CNT_REG_W-1:0] count_r;

  // path memory
  logic [3*CRD_W-1:0] path_mem [MAX_POINTS];
  logic [3*CRD_W-1:0] rd_data_r;
  logic [PTR_W-1:0]   mem_addr;

  // sequencer and datapath
  state_t                  state_r, ret_r;
  logic                    follow_r, fin_r, move_r;
  logic signed [CRD_W-1:0] pos_r [3];
  logic signed [CRD_W-1:0] pa_r [3];
  logic signed [CRD_W-1:0] pb_r [3];
  logic signed [CRD_W-1:0] vel_r [3];
  logic [MAG_W-1:0]        dmag_r [3];
  logic                    dneg_r [3];
  logic [ACC_W-1:0]        acc_r, best_r;
  logic [RSQ_W-1:0]        rsqa_r, rsqh_r;
  logic [2:0]              mc_r;
  logic [1:0]              comp_r;
  logic [5:0]              it_r;
  logic [PTR_W-1:0]        k_r, j_r, near_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [REG_W-1:0]        rem_r;
  logic [ROOT_W-1:0]       len_r;
  logic [ROOT_W+2:0]       srem_r;
  logic [ROOT_W:0]         drem_r;
  logic [MAG_W-1:0]        q_r;

  // output register
  logic                    out_valid_r, out_follow_r;
  logic signed [CRD_W-1:0] out_vel_r [3];
  logic signed [CRD_W-1:0] out_car_r [3];
  logic [PTR_W-1:0]        out_near_r;

  logic in_acc;
  logic emit_go;
  assign in_port.ready = (state_r == S_IDLE);
  assign in_acc = in_port.valid && in_port.ready;
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || out_port.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r    <= LOOKAHEAD_RST;
      speed_r   <= SPEED_RST;
      count_r   <= COUNT_RST;
      arrival_r <= ARRIVAL_RST;
      hover_r   <= HOVER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOKAHEAD: look_r    <= cfg_wdata;
        CFG_SPEED:     speed_r   <= cfg_wdata;
        CFG_COUNT:     count_r   <= cfg_wdata[CNT_REG_W-1:0];
        CFG_ARRIVAL:   arrival_r <= cfg_wdata;
        CFG_HOVER:     hover_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // writes happen only in idle, where the read data is not used
  always_ff @(posedge clk) begin
    if (in_acc && in_port.kind == KIND_POINT)
      path_mem[in_port.point_index] <= {in_port.coord_x, in_port.coord_y, in_port.coord_z};
    rd_data_r <= path_mem[mem_addr];
  end

  logic signed [CRD_W-1:0] rd_pt [3];
  assign rd_pt[0] = rd_data_r[3*CRD_W-1:2*CRD_W];
  assign rd_pt[1] = rd_data_r[2*CRD_W-1:CRD_W];
  assign rd_pt[2] = rd_data_r[CRD_W-1:0];

  // difference magnitudes
  logic signed [CRD_W-1:0] da [3];
  logic signed [CRD_W-1:0] db [3];
  logic signed [MAG_W-1:0] dif [3];
  logic [MAG_W-1:0]        dmag_c [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      da[c] = pb_r[c];
      db[c] = pos_r[c];
      if (state_r == S_WALK_DIFF) db[c] = pa_r[c];
      if (state_r == S_FIN_DIFF) da[c] = pa_r[c];
      dif[c] = {da[c][CRD_W-1], da[c]} - {db[c][CRD_W-1], db[c]};
      dmag_c[c] = dif[c][MAG_W-1] ? MAG_W'(-dif[c]) : MAG_W'(dif[c]);
    end
  end

  // shared multiplier: 33 x 17 per cycle, two passes per product
  logic [MAG_W-1:0]  dsel, mul_a;
  logic [16:0]       mul_b;
  logic [REG_W-1:0]  rsrc, num;
  logic [49:0]       prod;
  logic [ACC_W-1:0]  pp, acc_sum;

  always_comb begin
    unique case (state_r == S_SQD ? mc_r[2:1] : comp_r)
      2'd0: dsel = dmag_r[0];
      2'd1: dsel = dmag_r[1];
      default: dsel = dmag_r[2];
    endcase
    rsrc = mc_r[1] ? hover_r : arrival_r;
    num  = fin_r ? speed_r : rem_r;
    mul_a = dsel;
    mul_b = mc_r[0] ? {1'b0, dsel[32:17]} : dsel[16:0];
    if (state_r == S_RSQ) begin
      mul_a = {2'b0, rsrc};
      mul_b = mc_r[0] ? {3'b0, rsrc[30:17]} : rsrc[16:0];
    end else if (state_r == S_MD_MUL) begin
      mul_b = mc_r[0] ? {3'b0, num[30:17]} : num[16:0];
    end
    prod = 50'(mul_a) * 50'(mul_b);
    pp = mc_r[0] ? {1'b0, prod, 17'b0} : {18'b0, prod};
    acc_sum = acc_r + pp;
  end

  // square root step
  logic [ROOT_W+2:0] srem_t, trial;
  logic              sq_ge;
  assign srem_t = {srem_r[ROOT_W:0], acc_r[ACC_W-1:ACC_W-2]};
  assign trial  = {1'b0, len_r, 2'b01};
  assign sq_ge  = srem_t >= trial;

  // divide step
  logic [ROOT_W:0] dv_t;
  logic            dv_ge;
  assign dv_t  = {drem_r[ROOT_W-1:0], acc_r[ACC_W-1]};
  assign dv_ge = dv_t >= {1'b0, len_r};

  // scan and walk control
  logic             better, more_k, more_j, f_new;
  logic [PTR_W-1:0] near_new;
  logic signed [CRD_W+1:0] sval;
  assign better   = (k_r == '0) || (acc_r < best_r);
  assign near_new = better ? k_r : near_r;
  assign more_k   = ({1'b0, k_r} + CNT_W'(1)) < cnt_r;
  assign more_j   = ({1'b0, j_r} + CNT_W'(1)) < cnt_r;
  assign f_new    = follow_r || (acc_r < {6'b0, rsqa_r});
  assign sval     = dneg_r[comp_r] ? -(CRD_W+2)'({1'b0, q_r}) : (CRD_W+2)'({1'b0, q_r});

  always_comb begin
    mem_addr = '0;
    case (state_r)
      S_SCAN_CMP: mem_addr = more_k ? k_r + PTR_W'(1) : near_new;
      S_WALK_CHK: mem_addr = more_j ? j_r : PTR_W'(cnt_r - CNT_W'(1));
      S_WALK_LD1: mem_addr = j_r + PTR_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      follow_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mc_r        <= '0;
      comp_r      <= '0;
    end else begin
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_port.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_port.kind == KIND_POS) begin
            pos_r[0] <= in_port.coord_x;
            pos_r[1] <= in_port.coord_y;
            pos_r[2] <= in_port.coord_z;
            if (count_r == '0) cnt_r <= CNT_W'(1);
            else if (count_r > CNT_REG_W'(MAX_POINTS)) cnt_r <= CNT_W'(MAX_POINTS);
            else cnt_r <= CNT_W'(count_r);
            near_r  <= '0;
            fin_r   <= 1'b0;
            mc_r    <= '0;
            acc_r   <= '0;
            state_r <= S_RSQ;
          end
        end
        S_RSQ: begin
          mc_r <= mc_r + 3'd1;
          if (mc_r == 3'd1) begin
            rsqa_r <= acc_sum[RSQ_W-1:0];
            acc_r  <= '0;
          end else begin
            acc_r <= acc_sum;
          end
          if (mc_r == 3'd3) begin
            rsqh_r  <= acc_sum[RSQ_W-1:0];
            k_r     <= '0;
            state_r <= follow_r ? S_SCAN_LD : S_CAR_LD;
          end
        end
        S_CAR_LD: begin
          pa_r    <= rd_pt;
          state_r <= S_FIN_DIFF;
        end
        S_SCAN_LD: begin
          pb_r    <= rd_pt;
          state_r <= S_SCAN_DIFF;
        end
        S_SCAN_DIFF, S_WALK_DIFF, S_FIN_DIFF: begin
          for (int c = 0; c < 3; c++) begin
            dmag_r[c] <= dmag_c[c];
            dneg_r[c] <= dif[c][MAG_W-1];
          end
          acc_r <= '0;
          mc_r  <= '0;
          if (state_r == S_SCAN_DIFF) ret_r <= S_SCAN_CMP;
          else if (state_r == S_WALK_DIFF) ret_r <= S_SQRT;
          else begin
            ret_r <= S_FIN_TEST;
            fin_r <= 1'b1;
          end
          state_r <= S_SQD;
        end
        S_SQD: begin
          acc_r <= acc_sum;
          if (mc_r == 3'd5) begin
            mc_r    <= '0;
            srem_r  <= '0;
            len_r   <= '0;
            it_r    <= '0;
            state_r <= ret_r;
          end else begin
            mc_r <= mc_r + 3'd1;
          end
        end
        S_SCAN_CMP: begin
          if (better) begin
            best_r <= acc_r;
            near_r <= k_r;
          end
          if (more_k) begin
            k_r     <= k_r + PTR_W'(1);
            state_r <= S_SCAN_LD;
          end else begin
            j_r   <= near_new;
            rem_r <= look_r;
            state_r <= (look_r == '0) ? S_CAR_LD : S_WALK_CHK;
          end
        end
        S_WALK_CHK: state_r <= more_j ? S_WALK_LD1 : S_CAR_LD;
        S_WALK_LD1: begin
          pa_r    <= rd_pt;
          state_r <= S_WALK_LD2;
        end
        S_WALK_LD2: begin
          pb_r    <= rd_pt;
          state_r <= S_WALK_DIFF;
        end
        S_SQRT: begin
          srem_r <= sq_ge ? srem_t - trial : srem_t;
          len_r  <= {len_r[ROOT_W-2:0], sq_ge};
          acc_r  <= {acc_r[ACC_W-3:0], 2'b00};
          it_r   <= it_r + 6'd1;
          if (it_r == 6'(ROOT_W - 1)) state_r <= fin_r ? S_FIN_VEL : S_WALK_LEN;
        end
        S_WALK_LEN: begin
          if (len_r >= {3'b0, rem_r}) begin
            comp_r  <= '0;
            mc_r    <= '0;
            acc_r   <= '0;
            state_r <= S_MD_MUL;
          end else begin
            rem_r   <= rem_r - len_r[REG_W-1:0];
            j_r     <= j_r + PTR_W'(1);
            state_r <= S_WALK_CHK;
          end
        end
        S_FIN_TEST: begin
          follow_r <= f_new;
          move_r   <= (acc_r > STOP_EPS_SQ) && !(f_new && acc_r < {6'b0, rsqh_r});
          for (int c = 0; c < 3; c++) vel_r[c] <= '0;
          state_r  <= S_SQRT;
        end
        S_FIN_VEL: begin
          comp_r  <= '0;
          mc_r    <= '0;
          acc_r   <= '0;
          state_r <= move_r ? S_MD_MUL : S_EMIT;
        end
        S_MD_MUL: begin
          mc_r <= mc_r + 3'd1;
          if (mc_r[0]) begin
            // dividend stays below 2^63 and the quotient below 2^33
            drem_r  <= {5'b0, acc_sum[62:33]};
            acc_r   <= {acc_sum[32:0], 35'b0};
            q_r     <= '0;
            it_r    <= '0;
            state_r <= S_MD_DIV;
          end else begin
            acc_r <= acc_sum;
          end
        end
        S_MD_DIV: begin
          drem_r <= dv_ge ? dv_t - {1'b0, len_r} : dv_t;
          q_r    <= {q_r[MAG_W-2:0], dv_ge};
          acc_r  <= {acc_r[ACC_W-2:0], 1'b0};
          it_r   <= it_r + 6'd1;
          if (it_r == 6'(MAG_W - 1)) state_r <= S_MD_STORE;
        end
        S_MD_STORE: begin
          if (fin_r) vel_r[comp_r] <= sat_crd(sval);
          else pa_r[comp_r] <= pa_r[comp_r] + sval[CRD_W-1:0];
          if (comp_r == 2'd2) begin
            state_r <= fin_r ? S_EMIT : S_FIN_DIFF;
          end else begin
            comp_r  <= comp_r + 2'd1;
            mc_r    <= '0;
            acc_r   <= '0;
            state_r <= S_MD_MUL;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_vel_r    <= vel_r;
            out_car_r    <= pa_r;
            out_follow_r <= follow_r;
            out_near_r   <= near_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_port.valid         = out_valid_r;
  assign out_port.vel_x         = out_vel_r[0];
  assign out_port.vel_y         = out_vel_r[1];
  assign out_port.vel_z         = out_vel_r[2];
  assign out_port.carrot_x      = out_car_r[0];
  assign out_port.carrot_y      = out_car_r[1];
  assign out_port.carrot_z      = out_car_r[2];
  assign out_port.following     = out_follow_r;
  assign out_port.nearest_index = out_near_r;

  `CPF_ASSERT_NEXT(a_pos_busy, in_acc && in_port.kind == KIND_POS, !in_port.ready, "position word did not make the block busy")
  `CPF_ASSERT_NEXT(a_emit_loads, emit_go, out_valid_r && state_r == S_IDLE, "result word not loaded")
  `CPF_ASSERT_NEXT(a_follow_sticky, follow_r, follow_r, "following flag dropped")
  `CPF_ASSERT_NOW(a_near_zero, out_valid_r && !out_follow_r, out_near_r == '0, "nearest index set before following")
  `CPF_ASSERT_NOW(a_scan_range, state_r == S_SCAN_LD, {1'b0, k_r} < cnt_r, "scan index beyond point count")
  `CPF_ASSERT_NOW(a_walk_range, state_r == S_WALK_LD1, ({1'b0, j_r} + CNT_W'(1)) < cnt_r, "walk index beyond point count")

endmodule
